// File: rtl/psod_pkg.sv
// Shared types and constants for the periodic sixth-order derivative block.
// Used by psod_ctrl, psod_datapath, psod_arith and the top level; no dependencies.
package psod_pkg;

    localparam int SAMPLE_W   = 32;
    localparam int LEN_W      = 11;
    localparam int INV_W      = 24;
    localparam int CFG_W      = 24;
    localparam int POS_W      = 10;
    localparam int TDATA_W    = 48;
    localparam int TAPS       = 7;
    localparam int WIN_D      = 6;
    localparam int HEAD_D     = 6;
    localparam int EXT_D      = 12;
    localparam int HEAD_IDX_W = 3;
    localparam int TAIL_W     = 3;

    localparam int DEF_MAX_LINE = 1024;
    localparam int MIN_LINE     = 7;

    localparam logic [LEN_W-1:0]  LEN_RESET = 11'd128;
    localparam logic [INV_W-1:0]  INV_RESET = 24'd65536;
    localparam logic [TAIL_W-1:0] TAIL_LAST = 3'd5;

    typedef enum logic {
        REG_LINE_LENGTH = 1'b0,
        REG_INV_SPACING = 1'b1
    } t_reg_idx;

    typedef logic [SAMPLE_W-1:0] t_sample;

    // controller -> datapath
    typedef struct packed {
        logic                  shift;
        logic                  head_wr;
        logic [HEAD_IDX_W-1:0] head_idx;
        logic                  load_ext;
        logic                  sel_ext;
        logic                  issue;
        logic [POS_W-1:0]      pos;
        logic                  done;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic issue_ok;
    } t_dp_status;

endpackage

// File: rtl/psod_arith.sv
// Arithmetic pipeline: 7-tap stencil, inverse-spacing scale, divide by 60*2^16 with
// round-to-nearest and saturation. Depends on psod_pkg.
module psod_arith (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_valid,
    output logic                                         o_ready,
    input  psod_pkg::t_sample [psod_pkg::TAPS-1:0]       i_taps,
    input  logic [psod_pkg::POS_W-1:0]                   i_pos,
    input  logic                                         i_done,
    input  logic [psod_pkg::INV_W-1:0]                   i_inv,
    output logic                                         o_m_tvalid,
    input  logic                                         i_m_tready,
    output logic [psod_pkg::TDATA_W-1:0]                 o_m_tdata,   // [31:0] derivative, [41:32] position
    output logic                                         o_m_tuser,   // [0] saturated
    output logic                                         o_m_tlast
);
    import psod_pkg::*;

    localparam int STAGES      = 9;
    localparam int DIFF_W      = SAMPLE_W + 1;
    localparam int SUM_W       = 39;
    localparam int MAG_W       = 38;
    localparam int INV_H       = INV_W / 2;
    localparam int PP_W        = MAG_W + INV_H;
    localparam int PROD_W      = 63;
    localparam int ROUND_SHIFT = 18;
    localparam int QY_W        = PROD_W - ROUND_SHIFT;
    localparam int Z_W         = 35;
    localparam int RC_W        = 36;
    localparam int RC_H        = RC_W / 2;
    localparam int PM_W        = Z_W + RC_H;
    localparam int ACC_W       = Z_W + RC_W;
    localparam int RC_SHIFT    = 39;
    localparam int Q_W         = ACC_W - RC_SHIFT;
    localparam int R_W         = Q_W + 4;

    localparam logic [PROD_W-1:0] ROUND_HALF = 63'd1966080;       // half of 15 * 2^18
    localparam logic [RC_W-1:0]   RECIP15    = 36'd36650387592;   // floor(2^39 / 15)
    localparam logic [QY_W-1:0]   SAT_POS    = 45'd32212254720;   // 15 * 2^31
    localparam logic [QY_W-1:0]   SAT_NEG    = 45'd32212254735;   // 15 * (2^31 + 1)
    localparam logic [R_W-1:0]    DIV_K      = 36'd15;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic             done;
        logic             neg;
    } t_side;

    logic [STAGES-1:0] r_vld;
    logic [STAGES-1:0] adv;
    t_side             r_side [STAGES];

    logic signed [DIFF_W-1:0] r_d_out, r_d_mid, r_d_in;
    logic signed [SUM_W-1:0]  r_t_out, r_t_mid, r_t_in;
    logic signed [SUM_W-1:0]  r_sum;
    logic [MAG_W-1:0]         r_mag;
    logic [PP_W-1:0]          r_ppa, r_ppb;
    logic [QY_W-1:0]          r_y;
    logic                     r_over6, r_over7, r_sat;
    logic [Z_W-1:0]           r_z6, r_z7;
    logic [PM_W-1:0]          r_pml, r_pmh;
    logic [Q_W-1:0]           r_q1;
    logic [SAMPLE_W-1:0]      r_deriv;

    logic signed [SUM_W-1:0]  mid_x, in_x, abs_sum;
    logic [PROD_W-1:0]        prod;
    logic [Z_W-1:0]           z;
    logic [ACC_W-1:0]         acc;
    logic [R_W-1:0]           prod15, rem;
    logic [Q_W-1:0]           q;
    logic [SAMPLE_W-1:0]      deriv;
    logic                     over;

    // back-pressure: a stage loads when empty or when the next stage takes its word
    always_comb begin
        adv[STAGES-1] = !r_vld[STAGES-1] || i_m_tready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end
    assign o_ready = adv[0];

    always_comb begin
        mid_x   = SUM_W'(r_d_mid);
        in_x    = SUM_W'(r_d_in);
        abs_sum = r_sum[SUM_W-1] ? -r_sum : r_sum;
        prod    = PROD_W'(r_ppa) + (PROD_W'(r_ppb) << INV_H) + ROUND_HALF;
        z       = r_y[Z_W-1:0];
        over    = r_side[5].neg ? (r_y >= SAT_NEG) : (r_y >= SAT_POS);
        acc     = ACC_W'(r_pml) + (ACC_W'(r_pmh) << RC_H);
        prod15  = (R_W'(r_q1) << 4) - R_W'(r_q1);
        rem     = R_W'(r_z7) - prod15;
        q       = r_q1 + Q_W'(rem >= DIV_K);
        if (r_over7) begin
            deriv = r_side[7].neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            deriv = r_side[7].neg ? SAMPLE_W'(-q) : SAMPLE_W'(q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[0]) r_vld[0] <= i_valid;
            for (int k = 1; k < STAGES; k++) begin
                if (adv[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r_side[0] <= '{pos: i_pos, done: i_done, neg: 1'b0};
            r_d_out   <= DIFF_W'($signed(i_taps[6])) - DIFF_W'($signed(i_taps[0]));
            r_d_mid   <= DIFF_W'($signed(i_taps[1])) - DIFF_W'($signed(i_taps[5]));
            r_d_in    <= DIFF_W'($signed(i_taps[4])) - DIFF_W'($signed(i_taps[2]));
        end
        // stage 3 loads its side word together with the sign
        for (int k = 1; k < STAGES; k++) begin
            if (adv[k] && (k != 3)) r_side[k] <= r_side[k-1];
        end
        if (adv[1]) begin
            r_t_out <= SUM_W'(r_d_out);
            r_t_mid <= (mid_x <<< 3) + mid_x;
            r_t_in  <= (in_x <<< 5) + (in_x <<< 3) + (in_x <<< 2) + in_x;
        end
        if (adv[2]) begin
            r_sum <= r_t_out + r_t_mid + r_t_in;
        end
        if (adv[3]) begin
            r_mag     <= abs_sum[MAG_W-1:0];
            r_side[3] <= '{pos: r_side[2].pos, done: r_side[2].done, neg: r_sum[SUM_W-1]};
        end
        if (adv[4]) begin
            r_ppa <= PP_W'(r_mag) * PP_W'(i_inv[INV_H-1:0]);
            r_ppb <= PP_W'(r_mag) * PP_W'(i_inv[INV_W-1:INV_H]);
        end
        if (adv[5]) begin
            r_y <= prod[PROD_W-1:ROUND_SHIFT];
        end
        if (adv[6]) begin
            r_over6 <= over;
            r_z6    <= z;
            r_pml   <= PM_W'(z) * PM_W'(RECIP15[RC_H-1:0]);
            r_pmh   <= PM_W'(z) * PM_W'(RECIP15[RC_W-1:RC_H]);
        end
        if (adv[7]) begin
            r_q1    <= acc[ACC_W-1:RC_SHIFT];
            r_z7    <= r_z6;
            r_over7 <= r_over6;
        end
        if (adv[8]) begin
            r_deriv <= deriv;
            r_sat   <= r_over7;
        end
    end

    assign o_m_tvalid = r_vld[STAGES-1];
    assign o_m_tdata  = TDATA_W'({r_side[STAGES-1].pos, r_deriv});
    assign o_m_tuser  = r_sat;
    assign o_m_tlast  = r_side[STAGES-1].done;

endmodule

// File: rtl/psod_datapath.sv
// Datapath: sample window, head store, wrap-around tap line, inverse spacing register,
// and the arithmetic pipeline. Depends on psod_pkg and psod_arith.
module psod_datapath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  psod_pkg::t_dp_cmd                i_cmd,
    output psod_pkg::t_dp_status             o_status,
    input  psod_pkg::t_sample                i_sample,
    input  logic                             i_cfg_valid,
    input  logic                             i_cfg_index,
    input  logic [psod_pkg::CFG_W-1:0]       i_cfg_data,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [psod_pkg::TDATA_W-1:0]     o_m_tdata,   // [31:0] derivative, [41:32] position
    output logic                             o_m_tuser,   // [0] saturated
    output logic                             o_m_tlast
);
    import psod_pkg::*;

    t_sample              r_win  [WIN_D];
    t_sample              r_head [HEAD_D];
    t_sample              r_ext  [EXT_D];
    logic [INV_W-1:0]     r_inv;
    t_sample [TAPS-1:0]   taps;
    logic                 ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WIN_D; i++) r_win[i] <= '0;
            r_inv <= INV_RESET;
        end else begin
            if (i_cmd.shift) begin
                for (int i = 0; i < WIN_D - 1; i++) r_win[i] <= r_win[i+1];
                r_win[WIN_D-1] <= i_sample;
            end
            if (i_cfg_valid && (i_cfg_index == REG_INV_SPACING)) begin
                r_inv <= i_cfg_data[INV_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.head_wr) r_head[i_cmd.head_idx] <= i_sample;
    end

    // On the last sample, capture the line end followed by the line start; then
    // advance one position per wrapped result.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_ext) begin
            for (int i = 0; i < WIN_D - 1; i++) r_ext[i] <= r_win[i+1];
            r_ext[WIN_D-1] <= i_sample;
            for (int i = 0; i < HEAD_D; i++) r_ext[WIN_D+i] <= r_head[i];
        end else if (i_cmd.sel_ext && i_cmd.issue) begin
            for (int i = 0; i < EXT_D - 1; i++) r_ext[i] <= r_ext[i+1];
        end
    end

    always_comb begin
        for (int i = 0; i < WIN_D; i++) begin
            taps[i] = i_cmd.sel_ext ? r_ext[i] : r_win[i];
        end
        taps[TAPS-1] = i_cmd.sel_ext ? r_ext[TAPS-1] : i_sample;
    end

    psod_arith u_arith (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_cmd.issue),
        .o_ready    (ready),
        .i_taps     (taps),
        .i_pos      (i_cmd.pos),
        .i_done     (i_cmd.done),
        .i_inv      (r_inv),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    assign o_status.issue_ok = ready;

endmodule

// File: rtl/psod_ctrl.sv
// Line controller: sample counter, line length register and the wrap-around
// sequencer that issues the six wrapped results. Depends on psod_pkg.
module psod_ctrl #(
    parameter int MAX_LINE = psod_pkg::DEF_MAX_LINE
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    input  logic                         i_cfg_valid,
    input  logic                         i_cfg_index,
    input  logic [psod_pkg::CFG_W-1:0]   i_cfg_data,
    output psod_pkg::t_dp_cmd            o_cmd,
    input  psod_pkg::t_dp_status         i_status
);
    import psod_pkg::*;

    localparam int CNT_W = $clog2(MAX_LINE);
    localparam int NW    = ($clog2(MAX_LINE + 1) > LEN_W) ? $clog2(MAX_LINE + 1) : LEN_W;
    localparam logic [NW-1:0] N_MIN = NW'(MIN_LINE);
    localparam logic [NW-1:0] N_MAX = NW'(MAX_LINE);

    typedef enum logic {
        ST_RUN,
        ST_TAIL
    } t_state;

    t_state             r_state, n_state;
    logic [LEN_W-1:0]   r_len,   n_len;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [TAIL_W-1:0]  r_tail,  n_tail;

    logic [NW-1:0] len_ext, eff_n, count_ext, run_pos, tail_pos;
    logic          accept, last, head_phase, len_wr, in_tail;

    always_comb begin
        len_ext    = NW'(r_len);
        if (len_ext < N_MIN) begin
            eff_n = N_MIN;
        end else if (len_ext > N_MAX) begin
            eff_n = N_MAX;
        end else begin
            eff_n = len_ext;
        end
        count_ext  = NW'(r_count);
        last       = count_ext >= (eff_n - NW'(1));
        head_phase = r_count < CNT_W'(HEAD_D);
        in_tail    = (r_state == ST_TAIL);
        o_s_tready = !in_tail && i_status.issue_ok;
        accept     = i_s_tvalid && o_s_tready;
        len_wr     = i_cfg_valid && (i_cfg_index == REG_LINE_LENGTH);
        run_pos    = count_ext - NW'(3);
        // wrapped results: N-3, N-2, N-1, then 0, 1, 2
        tail_pos   = (r_tail < TAIL_W'(3)) ? (eff_n - NW'(3) + NW'(r_tail))
                                           : (NW'(r_tail) - NW'(3));

        o_cmd.shift    = accept;
        o_cmd.head_wr  = accept && head_phase;
        o_cmd.head_idx = r_count[HEAD_IDX_W-1:0];
        o_cmd.load_ext = accept && last;
        o_cmd.sel_ext  = in_tail;
        o_cmd.issue    = (accept && !head_phase) || (in_tail && i_status.issue_ok);
        o_cmd.pos      = in_tail ? tail_pos[POS_W-1:0] : run_pos[POS_W-1:0];
        o_cmd.done     = in_tail && (r_tail == TAIL_LAST);
    end

    always_comb begin
        n_state = r_state;
        n_len   = r_len;
        n_count = r_count;
        n_tail  = r_tail;
        unique case (r_state)
            ST_RUN: begin
                if (accept) begin
                    if (last) begin
                        n_count = '0;
                        n_tail  = '0;
                        n_state = ST_TAIL;
                    end else begin
                        n_count = r_count + CNT_W'(1);
                    end
                end
            end
            ST_TAIL: begin
                if (i_status.issue_ok) begin
                    if (r_tail == TAIL_LAST) begin
                        n_state = ST_RUN;
                    end else begin
                        n_tail = r_tail + TAIL_W'(1);
                    end
                end
            end
            default: n_state = ST_RUN;
        endcase
        // a new line length restarts the line
        if (len_wr) begin
            n_len   = i_cfg_data[LEN_W-1:0];
            n_count = '0;
            n_state = ST_RUN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_RUN;
            r_len   <= LEN_RESET;
            r_count <= '0;
            r_tail  <= '0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_count <= n_count;
            r_tail  <= n_tail;
        end
    end

endmodule

// File: rtl/periodic_sixth_order_derivative.sv
// Top level of the periodic sixth-order central first derivative.
// Depends on psod_pkg, psod_ctrl and psod_datapath.
//
//  channel   | direction | handshake               | payload
//  ----------+-----------+-------------------------+-----------------------------------
//  s (input) | in        | i_s_tvalid / o_s_tready | tdata[31:0] sample
//  m (output)| out       | o_m_tvalid / i_m_tready | tdata derivative, position; tuser
//            |           |                         | saturated; tlast line_done
//  cfg       | in        | i_cfg_valid/o_cfg_ready | index 0 line_length, 1 inv_spacing
//
// One sample per cycle unless stalled. The last sample of a line blocks input while
// the wrapped results issue from the head store, one per cycle unless stalled. Every
// result passes a nine-stage arithmetic pipeline (split multipliers for scale and
// divide). Synchronous active-low reset: line length 128, inverse spacing 1.0,
// counter cleared. Output stalls fill pipeline bubbles first, then hold the input.
module periodic_sixth_order_derivative #(
    parameter int MAX_LINE = psod_pkg::DEF_MAX_LINE
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [psod_pkg::SAMPLE_W-1:0]    i_s_tdata,   // [31:0] sample
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [psod_pkg::TDATA_W-1:0]     o_m_tdata,   // [31:0] derivative, [41:32] position
    output logic                             o_m_tuser,   // [0] saturated
    output logic                             o_m_tlast,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic                             i_cfg_index,
    input  logic [psod_pkg::CFG_W-1:0]       i_cfg_data
);
    import psod_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    assign o_cfg_ready = 1'b1;

    psod_ctrl #(
        .MAX_LINE (MAX_LINE)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    psod_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_sample    (i_s_tdata),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

endmodule
